### design/least_squares_line_fit_defines.svh
// Assertion macros for the line-fit block.
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define LSF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/lsf_pkg.sv
package lsf_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int SAMPLE_W       = 16;
    localparam int WIDE_W         = 128;
    localparam int HALF_W         = 64;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_FEW     = 3'd1;
    localparam logic [2:0] STATUS_CONST_X = 3'd2;
    localparam logic [2:0] STATUS_CONST_Y = 3'd3;
    localparam logic [2:0] STATUS_DROPPED = 3'd4;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_MATH,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        STEP_NSXX,
        STEP_SXSX,
        STEP_NSXY,
        STEP_SXSY,
        STEP_NSYY,
        STEP_SYSY,
        STEP_SLOPE,
        STEP_SLSX,
        STEP_ICPT,
        STEP_NSTDEN,
        STEP_NUMSQ,
        STEP_NN2,
        STEP_KDEN,
        STEP_SEDIV,
        STEP_SESQRT,
        STEP_DENNST,
        STEP_RDIV,
        STEP_RSQRT
    } t_step;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
        logic [5:0] frac;
    } t_arith_req;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Rounds a quotient carrying one extra fraction bit, saturates, applies the sign.
    function automatic logic signed [31:0] f_round(input logic [63:0] q2, input logic neg);
        logic [63:0] m;
        m = (q2 >> 1) + {63'd0, q2[0]};
        if (neg) begin
            if (m > 64'h8000_0000) begin
                m = 64'h8000_0000;
            end
            return -$signed(m[31:0]);
        end
        if (m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
        end
        return $signed(m[31:0]);
    endfunction

endpackage

### design/lsf_arith.sv
module lsf_arith (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lsf_pkg::t_arith_req     i_req,
    input  logic [127:0]            i_opa,
    input  logic [127:0]            i_opb,
    output logic                    o_done,
    output logic [127:0]            o_result
);
    import lsf_pkg::*;

    t_arith_op    r_op,   n_op;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [7:0]   r_cnt,  n_cnt;
    logic [127:0] r_opa,  n_opa;
    logic [127:0] r_opb,  n_opb;
    logic [128:0] r_acc,  n_acc;
    logic [63:0]  r_quo,  n_quo;
    logic         r_sat,  n_sat;

    logic [128:0] w_rem_sh;
    logic         w_ge;
    logic [63:0]  w_trial;

    always_comb begin
        w_rem_sh = {r_acc[127:0], r_opa[127]};
        w_ge     = w_rem_sh >= {1'b0, r_opb};
        w_trial  = r_quo + r_opb[63:0];
    end

    always_comb begin
        n_op   = r_op;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_opa  = r_opa;
        n_opb  = r_opb;
        n_acc  = r_acc;
        n_quo  = r_quo;
        n_sat  = r_sat;
        if (i_req.start) begin
            n_op   = i_req.op;
            n_busy = 1'b1;
            n_quo  = '0;
            n_sat  = 1'b0;
            n_acc  = '0;
            unique case (i_req.op)
                OP_MUL: begin
                    n_opa = {64'd0, i_opa[63:0]};
                    n_opb = {64'd0, i_opb[63:0]};
                    n_cnt = 8'(HALF_W - 1);
                end
                OP_DIV: begin
                    n_opa = i_opa;
                    n_opb = i_opb;
                    n_cnt = 8'(WIDE_W - 1) + {2'd0, i_req.frac};
                end
                OP_SQRT: begin
                    n_opa = {64'd0, i_opa[63:0]};
                    n_opb = {64'd0, 64'h4000_0000_0000_0000};
                    n_cnt = 8'(HALF_W / 2 - 1);
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    if (r_opa[0]) begin
                        n_acc = r_acc + {1'b0, r_opb};
                    end
                    n_opa = r_opa >> 1;
                    n_opb = r_opb << 1;
                end
                OP_DIV: begin
                    n_acc = w_ge ? w_rem_sh - {1'b0, r_opb} : w_rem_sh;
                    n_opa = r_opa << 1;
                    n_sat = r_sat | r_quo[63];
                    n_quo = {r_quo[62:0], w_ge};
                end
                OP_SQRT: begin
                    if (r_opa[63:0] >= w_trial) begin
                        n_opa = {64'd0, r_opa[63:0] - w_trial};
                        n_quo = (r_quo >> 1) + r_opb[63:0];
                    end else begin
                        n_quo = r_quo >> 1;
                    end
                    n_opb = r_opb >> 2;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_cnt <= n_cnt;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_sat <= n_sat;
    end

    always_comb begin
        unique case (r_op)
            OP_MUL:  o_result = r_acc[127:0];
            OP_DIV:  o_result = {64'd0, (r_sat ? 64'hFFFF_FFFF_FFFF_FFFF : r_quo)};
            OP_SQRT: o_result = {64'd0, r_quo};
            default: o_result = '0;
        endcase
    end

    assign o_done = r_done;

endmodule

### design/least_squares_line_fit.sv
// Least-squares line fit over a stream of (x, y) points in signed Q8.8. Points are taken
// one per cycle; each y goes into an on-chip store of MAX_POINTS entries and x, y, x*y and
// x*x are summed on the fly. Points past MAX_POINTS are dropped and reported with status 4
// unless the set is rejected. The item marked tlast closes the set: the block then stops
// taking points, reads the store once to form the sum of y squared, and works through the
// fit in one shared iterative unit for multiplies, divides and square roots, one step at a
// time, ending early when the set is rejected. Then one result item leaves with slope,
// intercept and standard error in Q16.16, correlation and determination in unsigned Q1.16
// and a status in tuser, and the sums start over. A finished result waits in an output
// register while the next set is loaded.
`include "least_squares_line_fit_defines.svh"

module least_squares_line_fit #(
    parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // x_value[15:0], y_value[31:16]
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [135:0] o_m_axis_tdata,   // slope, intercept, std_error, corr_coef, det_coef
    output logic [2:0]   o_m_axis_tuser    // status
);
    import lsf_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SXW = SAMPLE_W + CW;
    localparam int PW  = 2 * SAMPLE_W + CW;

    t_state r_state, n_state;
    t_step  r_step;

    logic [CW-1:0]         r_count;
    logic signed [SXW-1:0] r_sx, r_sy;
    logic signed [PW-1:0]  r_sxy, r_sxx, r_syy;
    logic                  r_ovf;

    logic signed [SAMPLE_W-1:0] r_y_mem [MAX_POINTS];
    logic signed [SAMPLE_W-1:0] r_rd_y;
    logic [CW-1:0]              r_addr;
    logic                       r_rd_valid;

    logic                 r_issued;
    logic signed [63:0]   r_den, r_num, r_nst;
    logic [127:0]         r_tmp, r_g, r_h;
    logic [63:0]          r_q;
    logic signed [31:0]   r_slope, r_icpt;
    logic [30:0]          r_se;
    logic [16:0]          r_corr, r_det;
    logic [2:0]           r_status;

    logic                 r_out_valid;
    logic [135:0]         r_out_data;
    logic [2:0]           r_out_user;

    logic                       w_in_acc, w_room, w_finish, w_done, w_load_out, w_start;
    logic signed [SAMPLE_W-1:0] w_x, w_y;
    logic signed [63:0]         w_n64, w_sx64, w_sy64, w_sxx64, w_sxy64, w_syy64;
    logic signed [63:0]         w_den_new;
    logic [63:0]                w_q_clamp;
    logic [127:0]               w_res, w_opa, w_opb;
    t_arith_req                 w_req;

    assign w_x      = i_s_axis_tdata[15:0];
    assign w_y      = i_s_axis_tdata[31:16];
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_room   = r_count < CW'(MAX_POINTS);

    assign w_n64   = 64'(r_count);
    assign w_sx64  = 64'(r_sx);
    assign w_sy64  = 64'(r_sy);
    assign w_sxx64 = 64'(r_sxx);
    assign w_sxy64 = 64'(r_sxy);
    assign w_syy64 = 64'(r_syy);

    assign w_den_new = $signed(r_tmp[63:0] - w_res[63:0]);
    assign w_q_clamp = (w_res[63:0] > 64'h1_0000_0000) ? 64'h1_0000_0000 : w_res[63:0];

    lsf_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_opa    (w_opa),
        .i_opb    (w_opb),
        .o_done   (w_done),
        .o_result (w_res)
    );

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_req.start = w_start;
        w_req.op    = OP_MUL;
        w_req.frac  = '0;
        unique case (r_step)
            STEP_NSXX:   begin w_opa[63:0] = w_n64;  w_opb[63:0] = w_sxx64; end
            STEP_SXSX:   begin w_opa[63:0] = w_sx64; w_opb[63:0] = w_sx64;  end
            STEP_NSXY:   begin w_opa[63:0] = w_n64;  w_opb[63:0] = w_sxy64; end
            STEP_SXSY:   begin w_opa[63:0] = w_sx64; w_opb[63:0] = w_sy64;  end
            STEP_NSYY:   begin w_opa[63:0] = w_n64;  w_opb[63:0] = w_syy64; end
            STEP_SYSY:   begin w_opa[63:0] = w_sy64; w_opb[63:0] = w_sy64;  end
            STEP_SLOPE: begin
                w_req.op    = OP_DIV;
                w_req.frac  = 6'd17;
                w_opa[63:0] = f_mag(r_num);
                w_opb[63:0] = r_den;
            end
            STEP_SLSX:   begin w_opa[63:0] = 64'(r_slope); w_opb[63:0] = w_sx64; end
            STEP_ICPT: begin
                w_req.op    = OP_DIV;
                w_req.frac  = 6'd1;
                w_opa[63:0] = f_mag($signed(r_tmp[63:0]));
                w_opb[63:0] = {w_n64[55:0], 8'd0};
            end
            STEP_NSTDEN: begin w_opa[63:0] = r_nst; w_opb[63:0] = r_den; end
            STEP_NUMSQ: begin
                w_opa[63:0] = f_mag(r_num);
                w_opb[63:0] = f_mag(r_num);
            end
            STEP_NN2:    begin w_opa[63:0] = w_n64; w_opb[63:0] = w_n64 - 64'sd2; end
            STEP_KDEN:   begin w_opa[63:0] = r_tmp[63:0]; w_opb[63:0] = r_den; end
            STEP_SEDIV: begin
                w_req.op   = OP_DIV;
                w_req.frac = 6'd16;
                w_opa      = r_h;
                w_opb      = r_tmp;
            end
            STEP_SESQRT: begin w_req.op = OP_SQRT; w_opa[63:0] = r_q; end
            STEP_DENNST: begin w_opa[63:0] = r_den; w_opb[63:0] = r_nst; end
            STEP_RDIV: begin
                w_req.op   = OP_DIV;
                w_req.frac = 6'd32;
                w_opa      = r_g;
                w_opb      = r_tmp;
            end
            STEP_RSQRT:  begin w_req.op = OP_SQRT; w_opa[63:0] = r_q; end
            default:     begin w_req.op = OP_MUL; end
        endcase
    end

    always_comb begin
        w_finish = 1'b0;
        if (r_state == S_MATH && w_done) begin
            unique case (r_step)
                STEP_SXSX:   w_finish = (r_count < CW'(3)) || (w_den_new <= 64'sd0);
                STEP_SESQRT: w_finish = (r_nst <= 64'sd0);
                STEP_RSQRT:  w_finish = 1'b1;
                default:     w_finish = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_count && !r_rd_valid) begin
                    n_state = S_MATH;
                end
            end
            S_MATH: begin
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_LOAD);
        w_start         = (r_state == S_MATH) && !r_issued;
        w_load_out      = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            r_y_mem[r_count[AW-1:0]] <= w_y;
        end
        r_rd_y <= r_y_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_step      <= STEP_NSXX;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxy       <= '0;
            r_sxx       <= '0;
            r_ovf       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                    r_sx    <= r_sx + SXW'(w_x);
                    r_sy    <= r_sy + SXW'(w_y);
                    r_sxy   <= r_sxy + PW'(w_x * w_y);
                    r_sxx   <= r_sxx + PW'(w_x * w_x);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_s_axis_tlast) begin
                    r_step <= STEP_NSXX;
                end
            end
            if (r_state == S_SCAN) begin
                r_rd_valid <= r_addr < r_count;
            end else begin
                r_rd_valid <= 1'b0;
            end
            if (w_start) begin
                r_issued <= 1'b1;
            end else if (w_done) begin
                r_issued <= 1'b0;
                if (!w_finish && r_step != STEP_RSQRT) begin
                    r_step <= t_step'(r_step + 5'd1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sx        <= '0;
                r_sy        <= '0;
                r_sxy       <= '0;
                r_sxx       <= '0;
                r_ovf       <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_s_axis_tlast) begin
            r_addr   <= '0;
            r_syy    <= '0;
            r_slope  <= '0;
            r_icpt   <= '0;
            r_se     <= '0;
            r_corr   <= '0;
            r_det    <= '0;
            r_status <= STATUS_OK;
        end
        if (r_state == S_SCAN) begin
            if (r_addr < r_count) begin
                r_addr <= r_addr + CW'(1);
            end
            if (r_rd_valid) begin
                r_syy <= r_syy + PW'(r_rd_y * r_rd_y);
            end
        end
        if (r_state == S_MATH && w_done) begin
            unique case (r_step)
                STEP_NSXX: r_tmp <= w_res;
                STEP_SXSX: begin
                    r_den <= w_den_new;
                    if (r_count < CW'(3)) begin
                        r_status <= STATUS_FEW;
                    end else if (w_den_new <= 64'sd0) begin
                        r_status <= STATUS_CONST_X;
                    end
                end
                STEP_NSXY: r_tmp <= w_res;
                STEP_SXSY: r_num <= $signed(r_tmp[63:0] - w_res[63:0]);
                STEP_NSYY: r_tmp <= w_res;
                STEP_SYSY: r_nst <= $signed(r_tmp[63:0] - w_res[63:0]);
                STEP_SLOPE: r_slope <= f_round(w_res[63:0], r_num[63]);
                STEP_SLSX: r_tmp <= {64'd0, (w_sy64 <<< 16) - w_res[63:0]};
                STEP_ICPT: r_icpt <= f_round(w_res[63:0], r_tmp[63]);
                STEP_NSTDEN: r_h <= w_res;
                STEP_NUMSQ: begin
                    r_g <= w_res;
                    r_h <= r_h - w_res;
                end
                STEP_NN2:   r_tmp <= w_res;
                STEP_KDEN:  r_tmp <= w_res;
                STEP_SEDIV: r_q <= w_res[63:0];
                STEP_SESQRT: begin
                    r_se <= (w_res[63:0] > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : w_res[30:0];
                    if (r_nst <= 64'sd0) begin
                        r_status <= STATUS_CONST_Y;
                    end
                end
                STEP_DENNST: r_tmp <= w_res;
                STEP_RDIV: begin
                    r_q   <= w_q_clamp;
                    r_det <= w_q_clamp[32:16];
                end
                STEP_RSQRT: begin
                    r_corr   <= w_res[16:0];
                    r_status <= r_ovf ? STATUS_DROPPED : STATUS_OK;
                end
                default: r_tmp <= r_tmp;
            endcase
        end
        if (w_load_out) begin
            r_out_data <= {7'd0, r_det, r_corr, r_se, r_icpt, r_slope};
            r_out_user <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `LSF_ASSERT_SAME(a_done_expected, i_clk, i_rst_n, w_done, r_state == S_MATH && r_issued)
    `LSF_ASSERT_SAME(a_drop_when_full, i_clk, i_rst_n, r_ovf, r_count == CW'(MAX_POINTS))
    `LSF_ASSERT_NEXT(a_out_taken, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && r_state != S_DONE, !o_m_axis_tvalid)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lsf_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               hold;
        int                 mode;
    } t_point;

    typedef struct {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [30:0]        std_error;
        logic [16:0]        corr_coef;
        logic [16:0]        det_coef;
        logic [2:0]         status;
    } t_fit;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;

    least_squares_line_fit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    t_point pending_points[$];
    t_fit   fit_expected[$];
    longint set_y[$];
    int     set_count;
    longint sum_x, sum_y, sum_xy, sum_xx;
    bit     dropped_seen;
    int     sent_count, taken_count;
    int     mismatches;
    int     cur_mode;
    bit     stim_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] frac_div(input logic [127:0] num,
                                             input logic [127:0] den, input int frac);
        logic [191:0] w;
        logic [191:0] q;
        if (den == 0) return '1;
        w = {64'd0, num} << frac;
        q = w / {64'd0, den};
        return (q[191:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint round_q(input logic [63:0] q2, input bit neg);
        logic [63:0] m;
        m = (q2 >> 1) + {63'd0, q2[0]};
        if (neg) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return longint'(m);
    endfunction

    task automatic fit_point(input logic signed [15:0] xv, input logic signed [15:0] yv,
                             input logic last);
        longint      x, y, n, den, num, syy, nst, slope, icpt, t;
        logic [63:0] q, se;
        logic [127:0] wn, wd;
        t_fit        r;
        x = xv;
        y = yv;
        if (set_count < MAX_POINTS_DEF) begin
            set_y = {set_y, y};
            set_count++;
            sum_x += x;
            sum_y += y;
            sum_xy += x * y;
            sum_xx += x * x;
        end else begin
            dropped_seen = 1;
        end
        if (!last) return;
        r = '{0, 0, 0, 0, 0, STATUS_OK};
        n = set_count;
        den = n * sum_xx - sum_x * sum_x;
        if (n < 3) begin
            r.status = STATUS_FEW;
        end else if (den <= 0) begin
            r.status = STATUS_CONST_X;
        end else begin
            num = n * sum_xy - sum_x * sum_y;
            syy = 0;
            foreach (set_y[i]) syy += set_y[i] * set_y[i];
            nst = n * syy - sum_y * sum_y;
            q = frac_div(abs64(num), 64'(den), 17);
            slope = round_q(q, num < 0);
            t = sum_y * 65536 - slope * sum_x;
            q = frac_div(abs64(t), 64'(n * 256), 1);
            icpt = round_q(q, t < 0);
            wn = 128'(64'(nst)) * 128'(64'(den)) - 128'(abs64(num)) * 128'(abs64(num));
            wd = 128'(64'(n * (n - 2))) * 128'(64'(den));
            se = root_floor(frac_div(wn, wd, 16));
            if (se > 64'h7FFF_FFFF) se = 64'h7FFF_FFFF;
            r.slope = slope[31:0];
            r.intercept = icpt[31:0];
            r.std_error = se[30:0];
            if (nst <= 0) begin
                r.status = STATUS_CONST_Y;
            end else begin
                q = frac_div(128'(abs64(num)) * 128'(abs64(num)),
                             128'(64'(den)) * 128'(64'(nst)), 32);
                if (q > (64'd1 << 32)) q = 64'd1 << 32;
                r.corr_coef = 17'(root_floor(q));
                r.det_coef = 17'(q >> 16);
                r.status = dropped_seen ? STATUS_DROPPED : STATUS_OK;
            end
        end
        fit_expected = {fit_expected, r};
        set_y.delete();
        set_count = 0;
        sum_x = 0;
        sum_y = 0;
        sum_xy = 0;
        sum_xx = 0;
        dropped_seen = 0;
    endtask

    task automatic add_point(input int xv, input int yv, input bit last, input int mode,
                             input bit hold = 0);
        t_point p;
        p.x = 16'(xv);
        p.y = 16'(yv);
        p.last = last;
        p.hold = hold;
        p.mode = mode;
        pending_points = {pending_points, p};
    endtask

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    always @(posedge i_clk) begin
        t_fit got;
        t_fit want;
        if (i_rst_n && s_tvalid && s_tready) begin
            fit_point(s_tdata[15:0], s_tdata[31:16], s_tlast);
            taken_count <= taken_count + 1;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.slope = m_tdata[31:0];
            got.intercept = m_tdata[63:32];
            got.std_error = m_tdata[94:64];
            got.corr_coef = m_tdata[111:95];
            got.det_coef = m_tdata[128:112];
            got.status = m_tuser;
            if (fit_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %p", got);
            end else begin
                want = fit_expected.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        bit send_idle, recv_idle;
        send_idle = (cur_mode == 1 || cur_mode == 3) && chance(47);
        recv_idle = (cur_mode == 2 || cur_mode == 3) && chance(47);
        if (cur_mode == 3) begin
            send_idle = chance(24);
            recv_idle = chance(24);
        end
        m_tready <= i_rst_n && !recv_idle;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || sent_count == taken_count) begin
            if (pending_points.size() != 0 && !send_idle &&
                !(pending_points[0].hold && fit_expected.size() != 0)) begin
                t_point p;
                p = pending_points.pop_front();
                cur_mode = p.mode;
                s_tdata <= {p.y, p.x};
                s_tlast <= p.last;
                s_tvalid <= 1'b1;
                sent_count <= sent_count + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    initial begin
        int total, size, kind, sx, sy, a, mode;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        sent_count = 0;
        taken_count = 0;
        mismatches = 0;
        cur_mode = 0;
        stim_done = 0;
        set_count = 0;
        sum_x = 0;
        sum_y = 0;
        sum_xy = 0;
        sum_xx = 0;
        dropped_seen = 0;
        i_rst_n = 0;
        add_point(100, 200, 1, 0);
        add_point(-32768, 32767, 0, 0);
        add_point(32767, -32768, 1, 0);
        for (int i = 0; i < 4; i++) add_point(-32768, i * 1000, i == 3, 0);
        for (int i = 0; i < 4; i++) add_point(i * 5000 - 9000, 32767, i == 3, 0);
        add_point(-32768, -32768, 0, 0);
        add_point(32767, 32767, 0, 0);
        add_point(0, 0, 0, 0);
        add_point(32767, -32768, 1, 0);
        for (int i = 0; i < 5; i++) add_point(i * 256, i * 512 + 128, i == 4, 0, i == 0);
        total = 0;
        while (total < 700) begin
            mode = (total / 175) % 4;
            size = chance(10) ? $urandom_range(1, 2) : $urandom_range(3, 40);
            kind = $urandom_range(0, 9);
            a = $urandom_range(0, 8) - 4;
            sx = $urandom_range(0, 65535) - 32768;
            sy = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < size; i++) begin
                int xv, yv;
                xv = (kind == 0) ? sx : $urandom_range(0, 65535) - 32768;
                if (kind == 1) yv = sy;
                else if (kind < 6) yv = a * (xv / 8) + $urandom_range(0, 2000) - 1000;
                else yv = $urandom_range(0, 65535) - 32768;
                add_point(xv, yv, i == size - 1, mode, i == 0 && chance(5));
            end
            total += size;
        end
        for (int i = 0; i < 1030; i++)
            add_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                      i == 1029, 0);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        while (pending_points.size() != 0 || sent_count != taken_count ||
               fit_expected.size() != 0)
            @(negedge i_clk);
        repeat (3000) @(negedge i_clk);
        if (mismatches == 0 && fit_expected.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/lsf_pkg.sv
design/lsf_arith.sv
design/least_squares_line_fit.sv
verif/testbench.sv
